>>> design/bdasc_pkg.sv
// bdasc_pkg: shared types and constants for the binary to decimal ASCII converter.
// No dependencies; used by bdasc_ctrl, bdasc_dp and the top level.
`default_nettype none

package bdasc_pkg;

    localparam int DIGIT_W = 4;

    // '0' in ASCII; the low nibble is zero, so a digit is ORed in
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // largest BCD digit that needs no correction before a shift
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd4;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;
    localparam logic [DIGIT_W-1:0] RADIX        = 4'd10;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture a new value, clear BCD
        logic dabble;     // one add-3 and shift step
        logic next_digit; // move next BCD digit to the top
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic                 top_zero;
        logic [DIGIT_W-1:0]   top_digit;
    } sts_t;

endpackage

`default_nettype wire

>>> design/bdasc_dp.sv
// bdasc_dp: datapath with binary shift register and BCD register (double dabble).
// Depends on bdasc_pkg for command/status structs and constants.
`default_nettype none

module bdasc_dp #(
    parameter int VALUE_BITS = 16,
    parameter int NUM_DIGITS = 5
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [VALUE_BITS-1:0]   value,
    input  wire bdasc_pkg::cmd_t         cmd,
    output bdasc_pkg::sts_t              sts,
    output logic [5:0]                   digit_char
);

    localparam int BCD_W = NUM_DIGITS * bdasc_pkg::DIGIT_W;

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      bcd_adj;

    // add 3 to every digit above 4, digits are independent
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*bdasc_pkg::DIGIT_W +: bdasc_pkg::DIGIT_W] > bdasc_pkg::DABBLE_LIMIT)
            begin
                bcd_adj[i*bdasc_pkg::DIGIT_W +: bdasc_pkg::DIGIT_W] =
                    bcd_reg[i*bdasc_pkg::DIGIT_W +: bdasc_pkg::DIGIT_W] + bdasc_pkg::DABBLE_ADD;
            end
            else
            begin
                bcd_adj[i*bdasc_pkg::DIGIT_W +: bdasc_pkg::DIGIT_W] =
                    bcd_reg[i*bdasc_pkg::DIGIT_W +: bdasc_pkg::DIGIT_W];
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (cmd.load)
        begin
            bin_next = value;
            bcd_next = '0;
        end
        else if (cmd.dabble)
        begin
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
        end
        else if (cmd.next_digit)
        begin
            bcd_next = {bcd_reg[BCD_W-bdasc_pkg::DIGIT_W-1:0], {bdasc_pkg::DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg <= '0;
            bcd_reg <= '0;
        end
        else
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign sts.top_digit = bcd_reg[BCD_W-1 -: bdasc_pkg::DIGIT_W];
    assign sts.top_zero  = (sts.top_digit == '0);
    assign digit_char    = bdasc_pkg::ASCII_ZERO | {2'b00, sts.top_digit};

`ifndef ASSERT_OFF
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (bcd_reg == '0))
        else $error("BCD not cleared on load");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        sts.top_digit < bdasc_pkg::RADIX)
        else $error("top BCD digit out of range");
`endif

endmodule

`default_nettype wire

>>> design/bdasc_ctrl.sv
// bdasc_ctrl: controller FSM sequencing load, conversion, zero skip and emission.
// Depends on bdasc_pkg for the state encoding and command/status structs.
`default_nettype none

module bdasc_ctrl #(
    parameter int VALUE_BITS = 16,
    parameter int NUM_DIGITS = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   last,
    input  wire bdasc_pkg::sts_t   sts,
    output bdasc_pkg::cmd_t        cmd
);

    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int DIG_W = $clog2(NUM_DIGITS);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_BITS - 1);
    localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(NUM_DIGITS - 1);

    bdasc_pkg::state_t state_reg, state_next;
    logic [BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DIG_W-1:0]  dig_cnt_reg, dig_cnt_next;

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        case (state_reg)
            bdasc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = BIT_LAST;
                    state_next   = bdasc_pkg::ST_CONV;
                end
            end
            bdasc_pkg::ST_CONV:
            begin
                cmd.dabble = 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_LAST;
                    state_next   = bdasc_pkg::ST_SKIP;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            bdasc_pkg::ST_SKIP:
            begin
                // drop leading zeros, always keep the units digit
                if (sts.top_zero && (dig_cnt_reg != '0))
                begin
                    cmd.next_digit = 1'b1;
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = bdasc_pkg::ST_EMIT;
                end
            end
            bdasc_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (dig_cnt_reg == '0)
                    begin
                        state_next = bdasc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_digit = 1'b1;
                        dig_cnt_next   = dig_cnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = bdasc_pkg::ST_IDLE;
            end
        endcase
    end

    assign last = (dig_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bdasc_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a digit is pending");

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready did not drop after a request");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("not idle after final digit");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

>>> design/binary_to_decimal_ascii_digits.sv
// binary_to_decimal_ascii_digits: top level, unsigned binary to ASCII decimal digits.
// Depends on bdasc_pkg, bdasc_ctrl and bdasc_dp.
//
//  channel | signals                        | request contents
//  --------+--------------------------------+-------------------------------------
//  input   | in_valid / in_ready            | value: unsigned number
//  output  | out_valid / out_ready          | digit_char (ASCII '0'..'9'), last
//
// One request passes through a load, a double-dabble step per value bit, a skip step
// per suppressed leading zero plus one, then one digit per hand-off while out_ready is high.
// At VALUE_BITS = 16 skipped zeros and digits always add up to five; the serial
// BCD shifter (one input bit per cycle) sets the conversion length.
// Reset (rst_n, asynchronous) returns the controller to idle with in_ready high.
// A stalled out_ready holds the current digit and last;
// no new request is taken until the final digit of the number has been handed off.
`default_nettype none

module binary_to_decimal_ascii_digits #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [5:0]                 digit_char,
    output logic                       last
);

    // decimal digits needed for 2^VALUE_BITS - 1: ceil(VALUE_BITS * log10(2))
    localparam int NUM_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;

    bdasc_pkg::cmd_t cmd;
    bdasc_pkg::sts_t sts;

    bdasc_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .last      (last),
        .sts       (sts),
        .cmd       (cmd)
    );

    // digit_char comes straight off the BCD register, so it is held during stalls
    bdasc_dp #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .sts        (sts),
        .digit_char (digit_char)
    );

endmodule

`default_nettype wire

>>> tb/sv/binary_to_decimal_ascii_digits_tb.sv
// binary_to_decimal_ascii_digits_tb: self-checking bench for the binary to ASCII decimal
// digit converter; a directed table, then random numbers with random stalls on both sides.
// Depends on bdasc_pkg and binary_to_decimal_ascii_digits.

module binary_to_decimal_ascii_digits_tb;

    localparam int VBITS        = 16;
    localparam int RANDOM_COUNT = 185;
    localparam int CALM_TAIL    = 30;     // last random requests run with no idling
    localparam int SETTLE       = 40;     // > conversion latency of one request
    localparam int CYCLE_LIMIT  = 200000;

    // one expected digit on the output channel
    typedef struct packed {
        logic [5:0] ch;
        logic       is_last;
    } digit_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [VBITS-1:0] value;
    logic             out_valid;
    logic             out_ready;
    logic [5:0]       digit_char;
    logic             last;

    digit_t           pending_digits[$];   // digits still owed by the block, oldest first
    logic [VBITS-1:0] row_value[$];        // directed table: number sent
    string            row_text[$];         // directed table: typed digits, "" = use predictor

    int  errors         = 0;
    int  cycle_count    = 0;
    int  numbers_sent   = 0;
    int  digits_checked = 0;
    int  stall_cycles   = 0;
    int  widest         = 0;
    bit  idling_on      = 1'b0;    // gates random bubbles on both channels
    int  hold_left      = 0;

    binary_to_decimal_ascii_digits #(
        .VALUE_BITS (VBITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last       (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the total cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d digits outstanding",
                     cycle_count, pending_digits.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Predictor: split the number into decimal digits, least significant first,
    // then queue them most significant first. A zero still yields one '0'.
    function automatic void predict_digits(input logic [VBITS-1:0] num);
        logic [3:0]       rev [5];
        logic [VBITS-1:0] rest;
        digit_t           d;
        int               n;
        rest = num;
        n    = 0;
        do
        begin
            rev[n] = 4'(rest % bdasc_pkg::RADIX);
            rest   = rest / bdasc_pkg::RADIX;
            n++;
        end
        while (rest != 0);
        for (int k = n - 1; k >= 0; k--)
        begin
            d.ch      = bdasc_pkg::ASCII_ZERO | {2'b00, rev[k]};
            d.is_last = (k == 0);
            pending_digits.push_back(d);
        end
        if (n > widest)
            widest = n;
    endfunction

    // Typed expectation for table rows whose digits are obvious by eye.
    function automatic void queue_typed(input string txt);
        digit_t d;
        byte    c;
        for (int i = 0; i < txt.len(); i++)
        begin
            c         = txt[i];
            d.ch      = c[5:0];
            d.is_last = (i == txt.len() - 1);
            pending_digits.push_back(d);
        end
        if (txt.len() > widest)
            widest = txt.len();
    endfunction

    function automatic void add_row(input logic [VBITS-1:0] num, input string txt);
        row_value.push_back(num);
        row_text.push_back(txt);
    endfunction

    // Offer one request, optionally after an idle burst; returns right after the
    // accepting edge so the next call can keep in_valid high without a bubble.
    task automatic send_number(input logic [VBITS-1:0] num, input string txt, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= num;
        do
            @(posedge clk);
        while (!in_ready);
        if (txt.len() != 0)
            queue_typed(txt);
        else
            predict_digits(num);
        numbers_sent++;
    endtask

    task automatic wait_drained();
        while (pending_digits.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_gap();
        if (idling_on && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 4);
        return 0;
    endfunction

    // Random number, weighted by digit count so short numbers and decade
    // boundaries show up often next to wide ones.
    function automatic logic [VBITS-1:0] random_number();
        case ($urandom_range(0, 9))
            0:       return VBITS'($urandom_range(0, 9));
            1:       return VBITS'($urandom_range(10, 99));
            2:       return VBITS'($urandom_range(100, 999));
            3:       return VBITS'($urandom_range(1000, 9999));
            4:       return VBITS'($urandom_range(10000, 65535));
            5:
            begin
                // just below or at a power of ten
                case ($urandom_range(0, 7))
                    0:       return 16'd9;
                    1:       return 16'd10;
                    2:       return 16'd99;
                    3:       return 16'd100;
                    4:       return 16'd999;
                    5:       return 16'd1000;
                    6:       return 16'd9999;
                    default: return 16'd10000;
                endcase
            end
            default: return VBITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // Output side: check each handed-off digit, then pick out_ready for the next
    // edge. Stalls come in random bursts while idling is on.
    initial
    begin
        digit_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_digits.size() == 0)
                begin
                    $display("%0t: unexpected digit: expected none, got char %0d last %0b",
                             $time, digit_char, last);
                    errors++;
                end
                else
                begin
                    want = pending_digits.pop_front();
                    if (digit_char !== want.ch)
                    begin
                        $display("%0t: digit_char mismatch: expected %0d, got %0d",
                                 $time, want.ch, digit_char);
                        errors++;
                    end
                    if (last !== want.is_last)
                    begin
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.is_last, last);
                        errors++;
                    end
                    digits_checked++;
                end
            end
            if (!rst_n)
                out_ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                stall_cycles++;
                out_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(1, 4) - 1;
                stall_cycles++;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [VBITS-1:0] num;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        value     <= '0;
        out_ready <= 1'b0;

        // Directed table. Typed digits only where they are plain to see.
        add_row(16'd0,     "0");       // zero gives a single '0' right after reset
        add_row(16'd1,     "1");
        add_row(16'd9,     "9");
        add_row(16'd10,    "10");
        add_row(16'd65535, "65535");   // all ones, widest number
        add_row(16'd0,     "0");       // all zeros again, after a wide one
        add_row(16'd99,    "99");
        add_row(16'd100,   "100");
        add_row(16'd999,   "999");
        add_row(16'd1000,  "1000");
        add_row(16'd9999,  "9999");
        add_row(16'd10000, "10000");
        add_row(16'd32768, "32768");   // top bit alone
        add_row(16'd12345, "12345");
        add_row(16'hAAAA,  "");
        add_row(16'h5555,  "");
        add_row(16'd65534, "");
        add_row(16'd40960, "");
        add_row(16'd255,   "");
        add_row(16'd4096,  "");
        add_row(16'd50505, "");
        add_row(16'd7,     "");

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows back to back first, then with bubbles
        foreach (row_value[i])
        begin
            idling_on = (i >= 11);
            send_number(row_value[i], row_text[i], pick_gap());
        end

        // hold the sender until the block has emptied
        in_valid <= 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            // blocks of 25 alternate between bubbly and back-to-back traffic
            idling_on = (i < RANDOM_COUNT - CALM_TAIL) && ((i / 25) % 2 == 0);
            if (i == RANDOM_COUNT / 2)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            num = random_number();
            send_number(num, "", pick_gap());
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d numbers (up to %0d digits), checked %0d digits",
                 numbers_sent, widest, digits_checked);
        $display("Output channel stalled for %0d cycles in total", stall_cycles);
        if (errors == 0 && pending_digits.size() == 0)
            $display("No mismatches found");
        else
        begin
            if (pending_digits.size() != 0)
                $display("%0t: %0d digits never arrived", $time, pending_digits.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
design/bdasc_pkg.sv
design/bdasc_dp.sv
design/bdasc_ctrl.sv
design/binary_to_decimal_ascii_digits.sv
tb/sv/binary_to_decimal_ascii_digits_tb.sv
